[hw/rtl/step_toward_target_clamped_assert.svh]
// ----------------------------------------------------------------------------
// Step toward target: assertion macros
// Shared concurrent assertion forms for the step-toward-target datapath.
// ----------------------------------------------------------------------------
`ifndef STEP_TOWARD_TARGET_CLAMPED_ASSERT_SVH
`define STEP_TOWARD_TARGET_CLAMPED_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STTC_ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STTC_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/sttc_pkg.sv]
// ----------------------------------------------------------------------------
// Step toward target: package
// Default configuration constants for the step-toward-target block.
// ----------------------------------------------------------------------------
package sttc_pkg;

  // Default coordinate width, two's complement.
  localparam int unsigned COORD_BITS_DEF = 11;

endpackage

[hw/rtl/step_toward_target_clamped.sv]
// Throughput: one transaction per cycle while out_tready is high; every stage
// holds its own valid bit and a stage advances whenever it is empty or its
// successor advances. Depth is set by the square-root pipe (one root bit per
// stage) and the divider pipe (one quotient bit per stage).
// Reset: synchronous active-low rst_n empties every stage; no other state.
// ----------------------------------------------------------------------------
// Step toward target, clamped
// Moves a point one speed-sized step along the source-to-destination vector,
// using an exact integer square root for the vector length, and clamps the
// result so that it never passes the destination.
// ----------------------------------------------------------------------------
`include "step_toward_target_clamped_assert.svh"

module step_toward_target_clamped #(
  parameter int unsigned COORD_BITS = sttc_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Input channel
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // Fields from bit 0 up: source_x, source_y, dest_x, dest_y, current_x,
  // current_y (COORD_BITS each), speed (COORD_BITS-1), zero fill to bytes
  input  logic [((7*COORD_BITS-1+7)/8)*8-1:0]    in_tdata,
  // Result channel
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // Fields from bit 0 up: new_x, new_y (COORD_BITS+1 each), arrived,
  // zero fill to bytes
  output logic [((2*COORD_BITS+3+7)/8)*8-1:0]    out_tdata
);

  // Widths
  localparam int unsigned C      = COORD_BITS;
  localparam int unsigned OUT_W  = ((2*C+3+7)/8)*8;
  localparam int unsigned RT_W   = C + 1;          // root bits, sqrt steps
  localparam int unsigned SQ_W   = 2 * RT_W;       // padded sum of squares
  localparam int unsigned SQX_W  = 2 * C;          // one square
  localparam int unsigned NW     = 2 * C - 1;      // speed times |offset|
  localparam int unsigned Q      = C - 1;          // quotient bits, div steps

  // Stage map
  localparam int unsigned ST_A   = 0;              // offsets, magnitudes
  localparam int unsigned ST_B   = 1;              // products
  localparam int unsigned ST_C   = 2;              // sum of squares
  localparam int unsigned ST_R0  = 3;              // first root step
  localparam int unsigned ST_DI  = ST_R0 + RT_W;   // divider load
  localparam int unsigned ST_D0  = ST_DI + 1;      // first divide step
  localparam int unsigned ST_F   = ST_D0 + Q;      // step, add, clamp
  localparam int unsigned NSTG   = ST_F + 1;

  typedef struct packed {
    logic signed [C-1:0]  dx;
    logic signed [C-1:0]  dy;
    logic signed [C-1:0]  cx;
    logic signed [C-1:0]  cy;
    logic [C-2:0]         v;
    logic                 lx_neg;
    logic                 ly_neg;
    logic                 ly_zero;
    logic [C-1:0]         alx;
    logic [C-1:0]         aly;
    logic [SQX_W-1:0]     sqx;
    logic [SQX_W-1:0]     sqy;
    logic [NW-1:0]        nx;
    logic [NW-1:0]        ny;
    logic [SQ_W-1:0]      sq;
    logic [RT_W+1:0]      srem;
    logic [RT_W-1:0]      root;
    logic [RT_W:0]        rx;
    logic [RT_W:0]        ry;
    logic [Q-1:0]         qx;
    logic [Q-1:0]         qy;
    logic signed [C:0]    new_x;
    logic signed [C:0]    new_y;
    logic                 arrived;
  } stg_t;

  stg_t         st_r   [NSTG];
  stg_t         st_nxt [NSTG];
  logic [NSTG-1:0] vld_r;
  logic [NSTG:0]   adv;

  // Unpack the input transaction
  logic signed [C-1:0] in_sx, in_sy, in_dx, in_dy, in_cx, in_cy;
  logic [C-2:0]        in_v;

  assign in_sx = in_tdata[0*C +: C];
  assign in_sy = in_tdata[1*C +: C];
  assign in_dx = in_tdata[2*C +: C];
  assign in_dy = in_tdata[3*C +: C];
  assign in_cx = in_tdata[4*C +: C];
  assign in_cy = in_tdata[5*C +: C];
  assign in_v  = in_tdata[6*C +: C-1];

  // Bubble-collapsing advance chain: a stage moves when empty or when its
  // successor moves. The output stage moves when the sink takes the result.
  always_comb begin
    adv[NSTG] = out_tready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign in_tready = adv[0];

  // Per-stage next values
  always_comb begin
    logic signed [C:0]    lx, ly;
    logic [RT_W+1:0]      rem_w, trial;
    logic [RT_W:0]        dvx, dvy, dlen;
    logic signed [C:0]    qxs, qys, stx, sty, tx, ty, dxe, dye;
    logic                 x_zero, y_zero;

    lx = '0; ly = '0; rem_w = '0; trial = '0; dvx = '0; dvy = '0; dlen = '0;
    qxs = '0; qys = '0; stx = '0; sty = '0; tx = '0; ty = '0; dxe = '0; dye = '0;
    x_zero = 1'b0; y_zero = 1'b0;

    for (int i = 0; i < NSTG; i++) begin
      st_nxt[i] = (i == 0) ? st_r[0] : st_r[i-1];
    end

    // Offsets and their magnitudes
    lx = (C+1)'(in_dx) - (C+1)'(in_sx);
    ly = (C+1)'(in_dy) - (C+1)'(in_sy);
    st_nxt[ST_A].dx      = in_dx;
    st_nxt[ST_A].dy      = in_dy;
    st_nxt[ST_A].cx      = in_cx;
    st_nxt[ST_A].cy      = in_cy;
    st_nxt[ST_A].v       = in_v;
    st_nxt[ST_A].lx_neg  = lx[C];
    st_nxt[ST_A].ly_neg  = ly[C];
    st_nxt[ST_A].ly_zero = (ly == '0);
    st_nxt[ST_A].alx     = lx[C] ? C'(-lx) : C'(lx);
    st_nxt[ST_A].aly     = ly[C] ? C'(-ly) : C'(ly);

    // Squares and speed products
    st_nxt[ST_B].sqx = SQX_W'(st_r[ST_A].alx) * SQX_W'(st_r[ST_A].alx);
    st_nxt[ST_B].sqy = SQX_W'(st_r[ST_A].aly) * SQX_W'(st_r[ST_A].aly);
    st_nxt[ST_B].nx  = NW'(st_r[ST_A].v) * NW'(st_r[ST_A].alx);
    st_nxt[ST_B].ny  = NW'(st_r[ST_A].v) * NW'(st_r[ST_A].aly);

    // Sum of squares; clear the root accumulators
    st_nxt[ST_C].sq   = SQ_W'(st_r[ST_B].sqx) + SQ_W'(st_r[ST_B].sqy);
    st_nxt[ST_C].srem = '0;
    st_nxt[ST_C].root = '0;

    // Square root, one root bit per stage, top bit pair first
    for (int k = 0; k < RT_W; k++) begin
      rem_w = {st_r[ST_R0+k-1].srem[RT_W-1:0], st_r[ST_R0+k-1].sq[SQ_W-1 -: 2]};
      trial = {st_r[ST_R0+k-1].root, 2'b01};
      st_nxt[ST_R0+k].sq = {st_r[ST_R0+k-1].sq[SQ_W-3:0], 2'b00};
      if (rem_w >= trial) begin
        st_nxt[ST_R0+k].srem = rem_w - trial;
        st_nxt[ST_R0+k].root = {st_r[ST_R0+k-1].root[RT_W-2:0], 1'b1};
      end else begin
        st_nxt[ST_R0+k].srem = rem_w;
        st_nxt[ST_R0+k].root = {st_r[ST_R0+k-1].root[RT_W-2:0], 1'b0};
      end
    end

    // Divider load: the quotient fits in Q bits, so the high part of the
    // dividend is already below the divisor
    st_nxt[ST_DI].rx = (RT_W+1)'(st_r[ST_DI-1].nx >> Q);
    st_nxt[ST_DI].ry = (RT_W+1)'(st_r[ST_DI-1].ny >> Q);
    st_nxt[ST_DI].qx = '0;
    st_nxt[ST_DI].qy = '0;

    // Restoring divide, one quotient bit per stage for both axes
    for (int k = 0; k < Q; k++) begin
      dlen = {1'b0, st_r[ST_D0+k-1].root};
      dvx  = {st_r[ST_D0+k-1].rx[RT_W-1:0], st_r[ST_D0+k-1].nx[Q-1-k]};
      dvy  = {st_r[ST_D0+k-1].ry[RT_W-1:0], st_r[ST_D0+k-1].ny[Q-1-k]};
      st_nxt[ST_D0+k].rx = (dvx >= dlen) ? dvx - dlen : dvx;
      st_nxt[ST_D0+k].ry = (dvy >= dlen) ? dvy - dlen : dvy;
      st_nxt[ST_D0+k].qx = {st_r[ST_D0+k-1].qx[Q-2:0], (dvx >= dlen)};
      st_nxt[ST_D0+k].qy = {st_r[ST_D0+k-1].qy[Q-2:0], (dvy >= dlen)};
    end

    // Signed step with zero-step fallback, add, clamp at destination
    x_zero = (st_r[ST_F-1].qx == '0) || (st_r[ST_F-1].root == '0);
    y_zero = (st_r[ST_F-1].qy == '0) || (st_r[ST_F-1].root == '0);
    qxs = (C+1)'(st_r[ST_F-1].qx);
    qys = (C+1)'(st_r[ST_F-1].qy);
    if (x_zero) begin
      stx = st_r[ST_F-1].lx_neg ? -(C+1)'(1) : (C+1)'(1);
    end else begin
      stx = st_r[ST_F-1].lx_neg ? -qxs : qxs;
    end
    if (y_zero) begin
      sty = st_r[ST_F-1].ly_zero ? '0 :
            (st_r[ST_F-1].ly_neg ? -(C+1)'(1) : (C+1)'(1));
    end else begin
      sty = st_r[ST_F-1].ly_neg ? -qys : qys;
    end
    dxe = (C+1)'(st_r[ST_F-1].dx);
    dye = (C+1)'(st_r[ST_F-1].dy);
    tx  = (C+1)'(st_r[ST_F-1].cx) + stx;
    ty  = (C+1)'(st_r[ST_F-1].cy) + sty;
    // A negative step on x is exactly a negative x offset; on y likewise.
    if (st_r[ST_F-1].lx_neg) begin
      if (dxe >= tx) tx = dxe;
    end else begin
      if (dxe <= tx) tx = dxe;
    end
    if (st_r[ST_F-1].ly_neg) begin
      if (dye >= ty) ty = dye;
    end else begin
      if (dye <= ty) ty = dye;
    end
    st_nxt[ST_F].new_x   = tx;
    st_nxt[ST_F].new_y   = ty;
    st_nxt[ST_F].arrived = (tx == dxe) && (ty == dye);
  end

  // Stage registers: valid bits reset, payload just loads
  always_ff @(posedge clk) begin
    for (int i = 0; i < NSTG; i++) begin
      if (adv[i]) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (adv[i]) begin
          vld_r[i] <= (i == 0) ? in_tvalid : vld_r[i-1];
        end
      end
    end
  end

  // Result transaction
  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = OUT_W'({st_r[ST_F].arrived, st_r[ST_F].new_y, st_r[ST_F].new_x});

  // Assertions
  `STTC_ASSERT_IMP(a_arrived_at_dest, clk, rst_n,
    vld_r[ST_F] && st_r[ST_F].arrived,
    (st_r[ST_F].new_x == (C+1)'(st_r[ST_F].dx)) && (st_r[ST_F].new_y == (C+1)'(st_r[ST_F].dy)),
    "arrived flag set off the destination")
  `STTC_ASSERT_IMP(a_empty_out_accepts, clk, rst_n,
    !vld_r[NSTG-1], in_tready,
    "input stalled while the output stage is empty")
  `STTC_ASSERT_IMP(a_step_within_speed, clk, rst_n,
    vld_r[ST_F-1] && (st_r[ST_F-1].root != '0),
    ((C-1)'(st_r[ST_F-1].qx) <= st_r[ST_F-1].v) && ((C-1)'(st_r[ST_F-1].qy) <= st_r[ST_F-1].v),
    "step quotient exceeds speed")
  `STTC_ASSERT_NEXT(a_stalled_result_holds, clk, rst_n,
    out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata),
    "stalled result changed or dropped")

endmodule
